// ===== rtl/rme_pkg.sv =====
// Package with shared types, constants and the arc tangent table for the Euler angle converter.
package rme_pkg;

  localparam int ELEM_W  = 18;
  localparam int ANGLE_W = 19;
  localparam int VEC_W   = 36;
  localparam int Z_W     = 34;
  localparam int SQ_W    = 34;
  localparam int ROOT_W  = 17;

  localparam logic [1:0] LOCK_NORMAL = 2'd0;
  localparam logic [1:0] LOCK_NEG    = 2'd1;
  localparam logic [1:0] LOCK_POS    = 2'd2;

  localparam logic signed [Z_W-1:0]     PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANGLE_W-1:0] PI_Q16      = 19'sd205887;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q16 = 19'sd102944;
  localparam logic signed [ELEM_W-1:0]  ONE_Q16     = 18'sd65536;

  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [Z_W-1:0]     zacc_t;

  typedef struct packed {
    elem_t      r00;
    elem_t      r10;
    elem_t      r11;
    elem_t      r12;
    elem_t      r20;
    elem_t      r21;
    elem_t      r22;
    logic [1:0] lock;
  } front_beat_t;

  function automatic zacc_t atan_entry(input int i);
    zacc_t t;
    case (i)
      0: t = 34'sd843314857;
      1: t = 34'sd497837830;
      2: t = 34'sd263043837;
      3: t = 34'sd133525159;
      4: t = 34'sd67021687;
      5: t = 34'sd33543516;
      6: t = 34'sd16775851;
      7: t = 34'sd8388437;
      8: t = 34'sd4194283;
      9: t = 34'sd2097149;
      default: t = zacc_t'(64'sd2097152 >>> (i - 10)) >>> 1;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/rotation_matrix_to_euler.sv =====
// Top level of the rotation matrix to XYZ Euler angle converter.
// Takes one matrix a cycle while in_ready is high and returns one beat of angles per
// matrix, in order; each matrix passes through the 17-stage square root pipe followed
// by the CORDIC stage pipes.
// A two-entry queue separates the front end from the back end; the back end stalls as
// a whole when its output register is held.
module rotation_matrix_to_euler #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rme_pkg::elem_t        in_elem_r0c0,
  input  rme_pkg::elem_t        in_elem_r1c0,
  input  rme_pkg::elem_t        in_elem_r1c1,
  input  rme_pkg::elem_t        in_elem_r1c2,
  input  rme_pkg::elem_t        in_elem_r2c0,
  input  rme_pkg::elem_t        in_elem_r2c1,
  input  rme_pkg::elem_t        in_elem_r2c2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rme_pkg::angle_t       out_roll_angle,
  output rme_pkg::angle_t       out_pitch_angle,
  output rme_pkg::angle_t       out_yaw_angle,
  output logic [1:0]            out_lock_case
);
  import rme_pkg::*;

  logic        f_valid, f_ready, b_valid, b_ready;
  front_beat_t f_data, b_data;

  rme_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .r00(in_elem_r0c0), .r10(in_elem_r1c0), .r11(in_elem_r1c1), .r12(in_elem_r1c2),
    .r20(in_elem_r2c0), .r21(in_elem_r2c1), .r22(in_elem_r2c2),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  rme_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  rme_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_valid(out_valid), .out_ready(out_ready), .roll(out_roll_angle),
    .pitch(out_pitch_angle), .yaw(out_yaw_angle), .lock(out_lock_case)
  );

  a_lock_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lock_case != 2'd3)
    else $error("Invalid lock case code.");
  a_roll_locked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lock_case != LOCK_NORMAL |-> out_roll_angle == '0)
    else $error("Roll must be zero in a lock case.");
  a_pitch_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lock_case == LOCK_POS |-> out_pitch_angle == HALF_PI_Q16)
    else $error("Pitch must be half pi in the positive lock case.");
endmodule

// ===== rtl/rme_fifo.sv =====
// Short queue between the classifying front end and the arithmetic back end.
module rme_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  rme_pkg::front_beat_t wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output rme_pkg::front_beat_t rd_data
);
  import rme_pkg::*;

  front_beat_t mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule

// ===== rtl/rme_front.sv =====
// Front end: input register and lock case decision.
module rme_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rme_pkg::elem_t       r00,
  input  rme_pkg::elem_t       r10,
  input  rme_pkg::elem_t       r11,
  input  rme_pkg::elem_t       r12,
  input  rme_pkg::elem_t       r20,
  input  rme_pkg::elem_t       r21,
  input  rme_pkg::elem_t       r22,
  output logic                 q_valid,
  input  logic                 q_ready,
  output rme_pkg::front_beat_t q_data
);
  import rme_pkg::*;

  logic        vld_r;
  front_beat_t dat_r;
  logic [1:0]  lock;

  assign in_ready = !vld_r || q_ready;
  assign q_valid  = vld_r;
  assign q_data   = dat_r;

  always_comb begin
    if (r20 >= ONE_Q16) lock = LOCK_POS;
    else if (r20 <= -ONE_Q16) lock = LOCK_NEG;
    else lock = LOCK_NORMAL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (in_ready) vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) dat_r <= '{r00, r10, r11, r12, r20, r21, r22, lock};
  end
endmodule

// ===== rtl/rme_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module rme_isqrt #(
  parameter int LAT = 17
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rme_pkg::SQ_W-1:0]   rad,
  output logic [rme_pkg::ROOT_W-1:0] root
);
  import rme_pkg::*;

  logic [SQ_W-1:0]   rem_r  [LAT+1];
  logic [ROOT_W-1:0] root_r [LAT+1];

  always_comb begin
    rem_r[0]  = rad;
    root_r[0] = '0;
  end

  for (genvar s = 0; s < LAT; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic [SQ_W+1:0] trial;
    logic [SQ_W+1:0] cand;
    assign cand  = ({2'b0, SQ_W'(root_r[s])} << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
    assign trial = {2'b0, rem_r[s]} - cand;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[SQ_W+1]) begin
          rem_r[s+1]  <= trial[SQ_W-1:0];
          root_r[s+1] <= root_r[s] | (ROOT_W'(1) << B);
        end else begin
          rem_r[s+1]  <= rem_r[s];
          root_r[s+1] <= root_r[s];
        end
      end
    end
  end

  assign root = root_r[LAT];
endmodule

// ===== rtl/rme_cordic.sv =====
// Pipelined vectoring CORDIC giving a clamped signed Q2.16 arc tangent.
module rme_cordic #(
  parameter int STEPS = 18
) (
  input  logic            clk,
  input  logic            en,
  input  logic signed [rme_pkg::ELEM_W:0] y_in,
  input  logic signed [rme_pkg::ELEM_W:0] x_in,
  output rme_pkg::angle_t angle
);
  import rme_pkg::*;

  vec_t  x_r [STEPS+1];
  vec_t  y_r [STEPS+1];
  zacc_t z_r [STEPS+1];
  logic  zy_r [STEPS+1];
  logic  zx_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zy_r[0] <= (y_in == '0);
      zx_r[0] <= x_in[ELEM_W];
      if (x_in[ELEM_W]) begin
        x_r[0] <= -(vec_t'(x_in) <<< 14);
        y_r[0] <= -(vec_t'(y_in) <<< 14);
        z_r[0] <= (y_in > 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_r[0] <= vec_t'(x_in) <<< 14;
        y_r[0] <= vec_t'(y_in) <<< 14;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam zacc_t AT = atan_entry(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zy_r[i+1] <= zy_r[i];
        zx_r[i+1] <= zx_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + AT;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - AT;
        end
      end
    end
  end

  zacc_t zr;
  assign zr = (z_r[STEPS] + zacc_t'(8192)) >>> 14;

  always_comb begin
    if (zy_r[STEPS]) angle = zx_r[STEPS] ? PI_Q16 : '0;
    else if (zr > zacc_t'(PI_Q16)) angle = PI_Q16;
    else if (zr < -zacc_t'(PI_Q16)) angle = -PI_Q16;
    else angle = zr[ANGLE_W-1:0];
  end
endmodule

// ===== rtl/rme_back.sv =====
// Back end: square root, three CORDIC pipes and the output register.
module rme_back #(
  parameter int STEPS = 18
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  rme_pkg::front_beat_t q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rme_pkg::angle_t      roll,
  output rme_pkg::angle_t      pitch,
  output rme_pkg::angle_t      yaw,
  output logic [1:0]           lock
);
  import rme_pkg::*;

  localparam int SQL = ROOT_W;
  localparam int DEPTH = SQL + 1 + STEPS + 2;

  logic en;
  logic [DEPTH-1:0] vld_r;
  logic [1:0] lk_r [DEPTH-1];
  front_beat_t d_r [SQL+1];
  logic signed [2*ELEM_W-1:0] sq;
  logic [SQ_W-1:0] rad_r;
  logic [ROOT_W-1:0] root;
  angle_t a_yaw, a_pitch, a_roll;
  logic signed [ELEM_W:0] yx, px, rx;
  logic signed [ELEM_W:0] yy, py, ry;

  assign en = !vld_r[DEPTH-1] || out_ready;
  assign q_ready = en;
  assign out_valid = vld_r[DEPTH-1];
  assign sq = q_data.r20 * q_data.r20;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], q_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]  <= q_data;
      lk_r[0] <= q_data.lock;
      rad_r   <= (SQ_W'(1) << 32) - SQ_W'(sq);
      for (int k = 1; k < DEPTH - 1; k++) lk_r[k] <= lk_r[k-1];
      for (int k = 1; k <= SQL; k++) d_r[k] <= d_r[k-1];
    end
  end

  rme_isqrt #(.LAT(SQL)) u_sqrt (.clk(clk), .en(en), .rad(rad_r), .root(root));

  always_comb begin
    case (d_r[SQL].lock)
      LOCK_POS: begin
        yy = (ELEM_W+1)'(d_r[SQL].r12);
        yx = (ELEM_W+1)'(d_r[SQL].r11);
      end
      LOCK_NEG: begin
        yy = -((ELEM_W+1)'(d_r[SQL].r12));
        yx = (ELEM_W+1)'(d_r[SQL].r11);
      end
      default: begin
        yy = -((ELEM_W+1)'(d_r[SQL].r10));
        yx = (ELEM_W+1)'(d_r[SQL].r00);
      end
    endcase
    py = (ELEM_W+1)'(d_r[SQL].r20);
    px = $signed({2'b0, root});
    ry = -((ELEM_W+1)'(d_r[SQL].r21));
    rx = (ELEM_W+1)'(d_r[SQL].r22);
  end

  rme_cordic #(.STEPS(STEPS)) u_yaw (.clk(clk), .en(en), .y_in(yy), .x_in(yx), .angle(a_yaw));
  rme_cordic #(.STEPS(STEPS)) u_pitch (.clk(clk), .en(en), .y_in(py), .x_in(px),
    .angle(a_pitch));
  rme_cordic #(.STEPS(STEPS)) u_roll (.clk(clk), .en(en), .y_in(ry), .x_in(rx),
    .angle(a_roll));

  logic [1:0] lf;
  assign lf = lk_r[DEPTH-2];

  always_ff @(posedge clk) begin
    if (en) begin
      lock <= lf;
      case (lf)
        LOCK_POS: begin
          pitch <= HALF_PI_Q16;
          roll  <= '0;
          yaw   <= a_yaw;
        end
        LOCK_NEG: begin
          pitch <= -HALF_PI_Q16;
          roll  <= '0;
          yaw   <= -a_yaw;
        end
        default: begin
          pitch <= a_pitch;
          roll  <= a_roll;
          yaw   <= a_yaw;
        end
      endcase
    end
  end
endmodule

// ===== tb/tb_rotation_matrix_to_euler.sv =====
// Self-checking testbench for the rotation matrix to Euler angle converter.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler;
  import rme_pkg::*;

  localparam int STEPS = 18;
  localparam int LATENCY = 1 + STEPS + 20;
  localparam longint PIQ30 = 64'd3373259426;
  localparam longint PIQ16 = 205887;

  typedef struct {
    logic [17:0] e [7];
  } matrix_t;

  typedef struct {
    logic [18:0] roll;
    logic [18:0] pitch;
    logic [18:0] yaw;
    logic [1:0]  lock;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  elem_t in_e [7];
  logic out_valid;
  logic out_ready = 1'b0;
  angle_t out_roll_angle, out_pitch_angle, out_yaw_angle;
  logic [1:0] out_lock_case;

  matrix_t pending_mats [$];
  angles_t expected_angles [$];
  int mismatches = 0;
  bit stim_done = 0;
  int hold_off = 0;
  bit hold_used = 0;
  int burst_left = 0, gap_left = 0, stall_phase = 0;

  rotation_matrix_to_euler #(.CORDIC_STEPS(STEPS)) uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_elem_r0c0(in_e[0]), .in_elem_r1c0(in_e[1]), .in_elem_r1c1(in_e[2]),
    .in_elem_r1c2(in_e[3]), .in_elem_r2c0(in_e[4]), .in_elem_r2c1(in_e[5]),
    .in_elem_r2c2(in_e[6]), .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_angle(out_roll_angle), .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle(out_yaw_angle), .out_lock_case(out_lock_case));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_pi(longint a);
    if (a > PIQ16) return PIQ16;
    if (a < -PIQ16) return -PIQ16;
    return a;
  endfunction

  function automatic longint arctan_term(int i);
    longint tab [10] = '{843314857, 497837830, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tab[i];
    return longint'(1) << (30 - i);
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (y == 0) return (x < 0) ? PIQ16 : 0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      z = (y > 0) ? PIQ30 : -PIQ30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += arctan_term(i);
      end else begin
        x = x - ys; y = y + xs; z -= arctan_term(i);
      end
    end
    return clamp_pi(floor_shift(z + 8192, 14));
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic angles_t euler_of(matrix_t m);
    longint r00, r10, r11, r12, r20, r21, r22, ro, pi_a, ya;
    angles_t a;
    r00 = longint'($signed(m.e[0])); r10 = longint'($signed(m.e[1]));
    r11 = longint'($signed(m.e[2])); r12 = longint'($signed(m.e[3]));
    r20 = longint'($signed(m.e[4])); r21 = longint'($signed(m.e[5]));
    r22 = longint'($signed(m.e[6]));
    if (r20 >= 65536) begin
      a.lock = LOCK_POS; pi_a = 102944; ro = 0; ya = cordic_atan2(r12, r11);
    end else if (r20 <= -65536) begin
      a.lock = LOCK_NEG; pi_a = -102944; ro = 0;
      ya = clamp_pi(-cordic_atan2(-r12, r11));
    end else begin
      a.lock = LOCK_NORMAL;
      ya = cordic_atan2(-r10, r00);
      pi_a = cordic_atan2(r20, floor_sqrt((longint'(1) << 32) - r20 * r20));
      ro = cordic_atan2(-r21, r22);
    end
    a.roll = ro[18:0]; a.pitch = pi_a[18:0]; a.yaw = ya[18:0];
    return a;
  endfunction

  function automatic logic [17:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 18'd65536;
      1: return -18'sd65536;
      2: return 18'($urandom);
      3: return 18'($urandom_range(0, 20) - 10);
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic matrix_t rotation_sample();
    matrix_t m;
    real a, b, c;
    a = ($urandom_range(0, 62831) - 31415) / 10000.0;
    b = ($urandom_range(0, 31415) - 15707) / 10000.0;
    c = ($urandom_range(0, 62831) - 31415) / 10000.0;
    m.e[0] = 18'($rtoi($cos(b) * $cos(c) * 65536.0));
    m.e[1] = 18'($rtoi($cos(b) * $sin(c) * 65536.0));
    m.e[2] = 18'($rtoi($cos(a) * $cos(c) * 65536.0));
    m.e[3] = 18'($rtoi($sin(a) * $cos(c) * 65536.0));
    m.e[4] = 18'($rtoi($sin(b) * 65536.0));
    m.e[5] = 18'($rtoi($sin(a) * $cos(b) * 65536.0));
    m.e[6] = 18'($rtoi($cos(a) * $cos(b) * 65536.0));
    return m;
  endfunction

  initial begin
    matrix_t m;
    logic [17:0] edges [6];
    edges = '{18'd65536, -18'sd65536, 18'h1FFFF, 18'h20000, 18'd0, 18'h3FFFF};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < 7; j++) m.e[j] = edges[k];
      pending_mats.push_back(m);
    end
    for (int j = 0; j < 7; j++) m.e[j] = 18'd0;
    pending_mats.push_back(m);
    m.e[0] = -18'sd100; m.e[1] = 18'd0; m.e[4] = 18'd65535; pending_mats.push_back(m);
    m.e[0] = -18'sd100; m.e[1] = 18'd50; m.e[4] = -18'sd65535; pending_mats.push_back(m);
    m.e[0] = 18'd100; m.e[1] = -18'sd50; m.e[5] = 18'd30; m.e[6] = -18'sd40;
    pending_mats.push_back(m);
    m.e[4] = 18'd70000; m.e[2] = -18'sd300; m.e[3] = 18'd200; pending_mats.push_back(m);
    m.e[4] = -18'sd70000; pending_mats.push_back(m);
    m.e[4] = 18'd65536; m.e[3] = 18'd0; pending_mats.push_back(m);
    m.e[4] = -18'sd65536; m.e[2] = 18'd5; m.e[3] = -18'sd7; pending_mats.push_back(m);
    for (int n = 0; n < 850; n++) begin
      if ($urandom_range(0, 3) == 0)
        for (int j = 0; j < 7; j++) m.e[j] = rand_elem();
      else
        m = rotation_sample();
      pending_mats.push_back(m);
    end
    wait (pending_mats.size() == 0 && !in_valid);
    wait (expected_angles.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_angles.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    matrix_t m;
    if (rst_n) begin
      if (in_valid && in_ready) expected_angles.push_back(euler_of(pending_mats.pop_front()));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_mats.size() > ((in_valid && in_ready) ? 0 : 1) ||
                     (!(in_valid && in_ready) && pending_mats.size() > 0 && !in_valid)) begin
          m = (in_valid && in_ready) ? pending_mats[0] : pending_mats[0];
          for (int j = 0; j < 7; j++) in_e[j] <= m.e[j];
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
          end
        end else in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    angles_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat");
        end else begin
          w = expected_angles.pop_front();
          if (out_roll_angle !== w.roll || out_pitch_angle !== w.pitch ||
              out_yaw_angle !== w.yaw || out_lock_case !== w.lock) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       $signed(w.roll), $signed(w.pitch), $signed(w.yaw), w.lock,
                       out_roll_angle, out_pitch_angle, out_yaw_angle, out_lock_case);
          end
        end
      end
      stall_phase <= stall_phase + 1;
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else if (!hold_used && expected_angles.size() > 20) begin
        hold_used <= 1'b1;
        hold_off <= 300;
        out_ready <= 1'b0;
      end else if (stall_phase % 256 < 64) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
    end
  end

endmodule
